@@ design/q4j_pkg.sv @@
package q4j_pkg;

  localparam int NAT_W      = 16;
  localparam int NAT_ONE    = 16384;
  localparam int RND_BITS   = 16;
  localparam int RND_HALF   = 32768;
  localparam int DIV_SHIFT  = 32;
  localparam int OUT_W      = 64;
  localparam int CFG_W      = 63;

endpackage

@@ design/q4_jacobian_inverse.sv @@
// Throughput: one word per cycle; 3-stage Jacobian lanes, 2-stage split
// determinant multiply, four inverse lanes of one restoring step per stage.
// The whole pipe stalls while an output word waits on m_tready.
// Reset (rst, synchronous, active high) empties the pipe and clears det_threshold.
module q4_jacobian_inverse #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [q4j_pkg::CFG_W-1:0]    cfg_data,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  // node0_x, node0_y, node1_x, node1_y, node2_x, node2_y, node3_x, node3_y,
  // nat_xi, nat_eta
  input  logic [((8*COORD_WIDTH+2*q4j_pkg::NAT_W+7)/8)*8-1:0] s_tdata,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  // jac_xx, jac_xy, jac_yx, jac_yy, det_value, inv_xx, inv_xy, inv_yx, inv_yy
  output logic [((4*(COORD_WIDTH+2)+5*q4j_pkg::OUT_W+7)/8)*8-1:0] m_tdata,
  // status
  output logic                         m_tuser
);

  localparam int CW  = COORD_WIDTH;
  localparam int JW  = CW + 2;
  localparam int DW  = 2 * JW + 1;
  localparam int NW  = JW + q4j_pkg::DIV_SHIFT;
  localparam int OW  = q4j_pkg::OUT_W;
  localparam int NTW = q4j_pkg::NAT_W;
  localparam int EW  = (DW > OW + 1) ? DW : OW + 1;
  localparam int SB  = NW + 2;
  localparam int LAT = NW + 8;
  localparam int MW  = ((4 * JW + 5 * OW + 7) / 8) * 8;
  localparam int INV_LO = 4 * JW + OW;
  localparam logic signed [EW-1:0] DMAX = {{(EW-OW+1){1'b0}}, {(OW-1){1'b1}}};
  localparam logic signed [EW-1:0] DMIN = {{(EW-OW+1){1'b1}}, {(OW-1){1'b0}}};

  typedef struct packed {
    logic [3:0][JW-1:0] jac;
    logic [OW-1:0]      det;
    logic               degen;
  } side_t;

  localparam int CFG_W_L = q4j_pkg::CFG_W;
  logic                   en;
  logic [CFG_W_L-1:0]     det_threshold;
  logic                   vld [0:LAT-1];
  logic signed [CW-1:0]   px [0:3];
  logic signed [CW-1:0]   py [0:3];
  logic signed [NTW-1:0]  xi;
  logic signed [NTW-1:0]  eta;
  logic signed [JW-1:0]   jac [0:3];
  logic signed [JW-1:0]   jd1 [0:3];
  logic signed [JW-1:0]   jd2 [0:3];
  logic signed [DW-1:0]   det;
  logic signed [EW-1:0]   det_ext;
  logic [OW-1:0]          det_sat;
  logic signed [JW-1:0]   inv_num [0:3];
  logic signed [OW-1:0]   inv [0:3];
  side_t                  side [0:SB-1];
  logic [3:0][JW-1:0]     o_jac;
  logic [OW-1:0]          o_det;
  logic [3:0][OW-1:0]     o_inv;
  logic                   o_status;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      det_threshold <= '0;
    end else if (cfg_we) begin
      det_threshold <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < LAT; k++) begin
        vld[k] <= 1'b0;
      end
    end else if (en) begin
      vld[0] <= s_tvalid;
      for (int k = 1; k < LAT; k++) begin
        vld[k] <= vld[k-1];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      px[k] = $signed(s_tdata[2*k*CW +: CW]);
      py[k] = $signed(s_tdata[(2*k+1)*CW +: CW]);
    end
    xi  = $signed(s_tdata[8*CW +: NTW]);
    eta = $signed(s_tdata[8*CW+NTW +: NTW]);
  end

  q4j_jac_lane #(.CW(CW)) u_jac_xx (
    .clk(clk), .en(en), .a0(px[0]), .a1(px[1]), .b0(px[2]), .b1(px[3]),
    .nat(eta), .jac(jac[0])
  );
  q4j_jac_lane #(.CW(CW)) u_jac_xy (
    .clk(clk), .en(en), .a0(py[0]), .a1(py[1]), .b0(py[2]), .b1(py[3]),
    .nat(eta), .jac(jac[1])
  );
  q4j_jac_lane #(.CW(CW)) u_jac_yx (
    .clk(clk), .en(en), .a0(px[0]), .a1(px[3]), .b0(px[2]), .b1(px[1]),
    .nat(xi), .jac(jac[2])
  );
  q4j_jac_lane #(.CW(CW)) u_jac_yy (
    .clk(clk), .en(en), .a0(py[0]), .a1(py[3]), .b0(py[2]), .b1(py[1]),
    .nat(xi), .jac(jac[3])
  );

  q4j_det #(.JW(JW)) u_det (
    .clk(clk), .en(en), .j00(jac[0]), .j01(jac[1]), .j10(jac[2]), .j11(jac[3]),
    .det(det)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        jd1[k] <= jac[k];
        jd2[k] <= jd1[k];
      end
    end
  end

  assign inv_num[0] = jd2[3];
  assign inv_num[1] = -jd2[1];
  assign inv_num[2] = -jd2[2];
  assign inv_num[3] = jd2[0];

  for (genvar g = 0; g < 4; g++) begin : g_div
    q4j_div_lane #(.JW(JW)) u_div (
      .clk(clk), .en(en), .num(inv_num[g]), .det(det), .quo(inv[g])
    );
  end

  always_comb begin
    det_ext = EW'(det);
    priority if (det_ext > DMAX) begin
      det_sat = DMAX[OW-1:0];
    end else if (det_ext < DMIN) begin
      det_sat = DMIN[OW-1:0];
    end else begin
      det_sat = det_ext[OW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        side[0].jac[k] <= jd2[k];
      end
      side[0].det   <= det_sat;
      side[0].degen <= !($signed({{(EW-CFG_W_L){1'b0}}, det_threshold}) < det_ext);
      for (int k = 1; k < SB; k++) begin
        side[k] <= side[k-1];
      end
    end
  end

  // merge: zero the inverse on a degenerate determinant
  always_ff @(posedge clk) begin
    if (en) begin
      o_jac    <= side[SB-1].jac;
      o_det    <= side[SB-1].det;
      o_status <= side[SB-1].degen;
      for (int k = 0; k < 4; k++) begin
        o_inv[k] <= side[SB-1].degen ? '0 : inv[k];
      end
    end
  end

  assign m_tdata = MW'({o_inv, o_det, o_jac});
  assign m_tuser = o_status;

`ifndef SYNTHESIS
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> (m_tdata[INV_LO +: 4*OW] == '0))
    else $error("degenerate word with nonzero inverse");
  a_ok_det_pos: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> !m_tdata[INV_LO-1])
    else $error("inverse reported for negative determinant");
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");
`endif

endmodule

@@ design/q4j_jac_lane.sv @@
module q4j_jac_lane #(
  parameter int CW = 32
) (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [CW-1:0]              a0,
  input  logic signed [CW-1:0]              a1,
  input  logic signed [CW-1:0]              b0,
  input  logic signed [CW-1:0]              b1,
  input  logic signed [q4j_pkg::NAT_W-1:0]  nat,
  output logic signed [CW+1:0]              jac
);

  localparam int JW  = CW + 2;
  localparam int FW  = 18;
  localparam int DFW = CW + 1;
  localparam int PW  = CW + 20;
  localparam logic signed [PW-1:0] JMAX = {{(PW-JW+1){1'b0}}, {(JW-1){1'b1}}};
  localparam logic signed [PW-1:0] JMIN = {{(PW-JW+1){1'b1}}, {(JW-1){1'b0}}};

  logic signed [FW-1:0]    f1;
  logic signed [FW-1:0]    f2;
  logic signed [DFW-1:0]   d1;
  logic signed [DFW-1:0]   d2;
  logic signed [PW-2:0]    p1;
  logic signed [PW-2:0]    p2;
  logic signed [PW-1:0]    sum;
  logic signed [PW-1:0]    rnd;
  logic signed [JW-1:0]    sat;

  always_comb begin
    sum = PW'(p1) + PW'(p2) + PW'(q4j_pkg::RND_HALF);
    rnd = sum >>> q4j_pkg::RND_BITS;
    priority if (rnd > JMAX) begin
      sat = JMAX[JW-1:0];
    end else if (rnd < JMIN) begin
      sat = JMIN[JW-1:0];
    end else begin
      sat = rnd[JW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1  <= FW'(q4j_pkg::NAT_ONE) - FW'(nat);
      f2  <= FW'(q4j_pkg::NAT_ONE) + FW'(nat);
      d1  <= DFW'(a1) - DFW'(a0);
      d2  <= DFW'(b0) - DFW'(b1);
      p1  <= f1 * d1;
      p2  <= f2 * d2;
      jac <= sat;
    end
  end

endmodule

@@ design/q4j_det.sv @@
module q4j_det #(
  parameter int JW = 34
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [JW-1:0]    j00,
  input  logic signed [JW-1:0]    j01,
  input  logic signed [JW-1:0]    j10,
  input  logic signed [JW-1:0]    j11,
  output logic signed [2*JW:0]    det
);

  localparam int DW = 2 * JW + 1;
  localparam int H  = JW / 2;
  localparam int HW = JW - H;

  logic signed [JW-1:0]     pa [0:1];
  logic signed [JW-1:0]     pb [0:1];
  logic signed [2*HW-1:0]   hh [0:1];
  logic signed [HW+H:0]     hl [0:1];
  logic signed [HW+H:0]     lh [0:1];
  logic [2*H-1:0]           ll [0:1];
  logic [DW-1:0]            prod [0:1];

  assign pa[0] = j00;
  assign pb[0] = j11;
  assign pa[1] = j01;
  assign pb[1] = j10;

  // split products: signed high half, unsigned low half
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 2; k++) begin
        hh[k] <= $signed(pa[k][JW-1:H]) * $signed(pb[k][JW-1:H]);
        hl[k] <= $signed(pa[k][JW-1:H]) * $signed({1'b0, pb[k][H-1:0]});
        lh[k] <= $signed({1'b0, pa[k][H-1:0]}) * $signed(pb[k][JW-1:H]);
        ll[k] <= pa[k][H-1:0] * pb[k][H-1:0];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      prod[k] = (DW'(hh[k]) << (2 * H)) + ((DW'(hl[k]) + DW'(lh[k])) << H)
              + DW'(ll[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      det <= $signed(prod[0] - prod[1]);
    end
  end

endmodule

@@ design/q4j_div_lane.sv @@
module q4j_div_lane #(
  parameter int JW = 34
) (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [JW-1:0]                num,
  input  logic signed [2*JW:0]                det,
  output logic signed [q4j_pkg::OUT_W-1:0]    quo
);

  localparam int DW = 2 * JW + 1;
  localparam int NW = JW + q4j_pkg::DIV_SHIFT;
  localparam int OW = q4j_pkg::OUT_W;
  localparam int QW = (NW + 1 > OW + 1) ? NW + 1 : OW + 1;
  localparam logic signed [QW-1:0] QMAX = {{(QW-OW+1){1'b0}}, {(OW-1){1'b1}}};
  localparam logic signed [QW-1:0] QMIN = {{(QW-OW+1){1'b1}}, {(OW-1){1'b0}}};

  logic [JW-1:0]     mag;
  logic [DW-1:0]     rem  [0:NW];
  logic [NW-1:0]     nreg [0:NW];
  logic [NW-1:0]     q    [0:NW];
  logic [DW-1:0]     dd   [0:NW];
  logic              neg  [0:NW];
  logic [DW-1:0]     rs   [0:NW-1];
  logic              ge   [0:NW-1];
  logic [QW-1:0]     qu;
  logic signed [QW-1:0] qs;
  logic signed [OW-1:0] qsat;

  assign mag = num[JW-1] ? JW'(~num + 1'b1) : num;

  // one restoring step per stage
  always_comb begin
    for (int i = 0; i < NW; i++) begin
      rs[i] = {rem[i][DW-2:0], nreg[i][NW-1]};
      ge[i] = (rs[i] >= dd[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg[0]  <= num[JW-1];
      nreg[0] <= {mag, {q4j_pkg::DIV_SHIFT{1'b0}}};
      rem[0]  <= '0;
      q[0]    <= '0;
      dd[0]   <= det;
      for (int i = 0; i < NW; i++) begin
        neg[i+1]  <= neg[i];
        dd[i+1]   <= dd[i];
        nreg[i+1] <= nreg[i] << 1;
        rem[i+1]  <= ge[i] ? (rs[i] - dd[i]) : rs[i];
        q[i+1]    <= {q[i][NW-2:0], ge[i]};
      end
      quo <= qsat;
    end
  end

  always_comb begin
    qu = QW'(q[NW]);
    qs = neg[NW] ? $signed(~qu + 1'b1) : $signed(qu);
    priority if (qs > QMAX) begin
      qsat = QMAX[OW-1:0];
    end else if (qs < QMIN) begin
      qsat = QMIN[OW-1:0];
    end else begin
      qsat = qs[OW-1:0];
    end
  end

endmodule
